// ===== design/app_pkg.sv =====
// Package for the antenna pan pointing block: constants, command types and the
// CORDIC arctangent table. Used by the controller, datapath and top level.
`timescale 1ns / 1ps
package app_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int COORD_W   = 24;
  localparam int DIFF_W    = 25;
  localparam int X_W       = 28;
  localparam int Z_W       = 18;
  localparam int ANG_W     = 16;
  localparam int DEG_W     = 9;
  localparam int SPAN_W    = 10;
  localparam int NUM_W     = 25;
  localparam int MAG_W     = 24;
  localparam int DIV_W     = 22;
  localparam int DIVR_W    = 9;
  localparam int SERVO_W   = 15;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 24;
  localparam int IN_W      = 64;
  localparam int OUT_W     = 32;
  localparam int SNAP_LIMIT = 31857;
  localparam int SERVO_FULL = 9600;

  localparam logic [CFG_IDX_W-1:0] REG_HOME_N  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOME_E  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PRE, ST_ROT, ST_PAN, ST_MUL, ST_DIV, ST_OUT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       pre;
    logic       iter;
    logic       pan;
    logic       mul;
    logic       div;
    logic       out_load;
    logic [4:0] cnt;
  } cmd_t;

  function automatic logic [13:0] atan_step(input logic [4:0] i);
    case (i)
      5'd0:    atan_step = 14'd8192;
      5'd1:    atan_step = 14'd4836;
      5'd2:    atan_step = 14'd2555;
      5'd3:    atan_step = 14'd1297;
      5'd4:    atan_step = 14'd651;
      5'd5:    atan_step = 14'd326;
      5'd6:    atan_step = 14'd163;
      5'd7:    atan_step = 14'd81;
      5'd8:    atan_step = 14'd41;
      5'd9:    atan_step = 14'd20;
      5'd10:   atan_step = 14'd10;
      5'd11:   atan_step = 14'd5;
      5'd12:   atan_step = 14'd3;
      5'd13:   atan_step = 14'd1;
      5'd14:   atan_step = 14'd1;
      default: atan_step = 14'd0;
    endcase
  endfunction

endpackage

// ===== design/app_ctrl.sv =====
// Controller of the antenna pan pointing block: sequences the CORDIC, the
// servo scaling and the divider. Depends on app_pkg.
`timescale 1ns / 1ps
module app_ctrl #(
  parameter int CORDIC_STEPS = app_pkg::CORDIC_STEPS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  output app_pkg::cmd_t cmd
);
  import app_pkg::*;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PRE;
        end
      end
      ST_PRE: begin
        cmd.pre   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_ROT;
      end
      ST_ROT: begin
        cmd.iter = 1'b1;
        if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_PAN;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_PAN: begin
        cmd.pan   = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (cnt_r == 5'(DIV_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_OUT;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      ST_OUT: begin
        // The result register is reloaded once the previous transfer has gone.
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== design/app_dp.sv =====
// Datapath of the antenna pan pointing block: configuration registers, the
// iterative CORDIC, hysteresis, servo scaling and a restoring divider.
// Depends on app_pkg.
`timescale 1ns / 1ps
module app_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  app_pkg::cmd_t                       cmd,
  input  logic signed [app_pkg::COORD_W-1:0]  plane_north,
  input  logic signed [app_pkg::COORD_W-1:0]  plane_east,
  input  logic signed [app_pkg::ANG_W-1:0]    heading,
  input  logic                                cfg_we,
  input  logic [app_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [app_pkg::CFG_W-1:0]           cfg_wdata,
  output logic signed [app_pkg::ANG_W-1:0]    pan_angle,
  output logic signed [app_pkg::SERVO_W-1:0]  servo_command
);
  import app_pkg::*;

  logic signed [COORD_W-1:0] home_n_r, home_e_r;
  logic signed [DEG_W-1:0]   neutral_r, max_r, min_r;
  logic                      side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_n_r  <= '0;
      home_e_r  <= '0;
      neutral_r <= '0;
      max_r     <= DEG_W'(90);
      min_r     <= -DEG_W'(90);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOME_N:  home_n_r  <= cfg_wdata;
        REG_HOME_E:  home_e_r  <= cfg_wdata;
        REG_NEUTRAL: neutral_r <= cfg_wdata[DEG_W-1:0];
        REG_MAX:     max_r     <= cfg_wdata[DEG_W-1:0];
        REG_MIN:     min_r     <= cfg_wdata[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  logic signed [DIFF_W-1:0] dn_r, de_r;
  logic signed [ANG_W-1:0]  hd_r;
  logic                     zero_r;
  logic signed [X_W-1:0]    x_r, y_r;
  logic signed [Z_W-1:0]    z_r;
  logic signed [ANG_W:0]    pan_r;
  logic signed [NUM_W-1:0]  num_r;
  logic signed [SPAN_W-1:0] span_r;
  logic [DIVR_W-1:0]        dv_r, rem_r;
  logic [DIV_W-1:0]         dvd_r;
  logic signed [ANG_W-1:0]  pan_out_r;
  logic signed [SERVO_W-1:0] servo_r;

  // CORDIC step, old x and y on both sides.
  logic [4:0]            sh;
  logic signed [X_W-1:0] xs, ys;
  logic signed [Z_W-1:0] at;
  assign sh = cmd.cnt;
  assign xs = x_r >>> sh;
  assign ys = y_r >>> sh;
  assign at = Z_W'($signed({1'b0, atan_step(sh)}));

  // Pan angle and hysteresis.
  logic signed [Z_W-1:0]   zsum;
  logic signed [ANG_W:0]   praw, pnew;
  logic                    side1, side2;
  logic signed [NUM_W-1:0] num_c;
  assign zsum = z_r + Z_W'(hd_r);
  assign praw = zero_r ? '0 : (ANG_W+1)'(signed'(zsum[ANG_W-1:0]));

  always_comb begin
    side1 = side_r;
    if (praw > 0 && praw <= SNAP_LIMIT) side1 = 1'b1;
    if (praw < 0 && praw >= -SNAP_LIMIT) side1 = 1'b0;
    pnew  = praw;
    side2 = side1;
    if (praw > SNAP_LIMIT && !side1) begin
      pnew = -(ANG_W+1)'(32768);
    end else if (praw < -SNAP_LIMIT && side1) begin
      pnew  = (ANG_W+1)'(32768);
      side2 = 1'b0;
    end
  end
  assign num_c = NUM_W'(pnew) * NUM_W'(180) - (NUM_W'(neutral_r) <<< 15);

  // Scaling: the factor 32768 of the divisor is taken off the dividend.
  logic [MAG_W-1:0]      mag;
  logic signed [SPAN_W-1:0] span_c;
  logic [MAG_W+13:0]     prod;
  assign mag    = num_r[NUM_W-1] ? MAG_W'(-num_r) : MAG_W'(num_r);
  assign span_c = (num_r > 0) ? (SPAN_W'(max_r) - SPAN_W'(neutral_r))
                              : (SPAN_W'(min_r) - SPAN_W'(neutral_r));
  assign prod   = (MAG_W+14)'(mag) * (MAG_W+14)'(SERVO_FULL);

  logic [DIVR_W:0] trial;
  logic            ge;
  assign trial = {rem_r, dvd_r[DIV_W-1]};
  assign ge    = trial >= {1'b0, dv_r};

  logic [13:0]               qsat;
  logic signed [SERVO_W-1:0] servo_c;
  always_comb begin
    qsat = (dvd_r > DIV_W'(SERVO_FULL)) ? 14'(SERVO_FULL) : dvd_r[13:0];
    if (span_r == 0) servo_c = (num_r == 0) ? '0 : SERVO_W'(SERVO_FULL);
    else if (span_r < 0) servo_c = -SERVO_W'(qsat);
    else servo_c = SERVO_W'(qsat);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) side_r <= 1'b0;
    else if (cmd.pan) side_r <= side2;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dn_r <= DIFF_W'(home_n_r) - DIFF_W'(plane_north);
      de_r <= DIFF_W'(home_e_r) - DIFF_W'(plane_east);
      hd_r <= heading;
    end
    if (cmd.pre) begin
      zero_r <= (dn_r == 0) && (de_r == 0);
      if (de_r < 0) begin
        if (dn_r >= 0) begin
          x_r <= X_W'(dn_r);
          y_r <= -X_W'(de_r);
          z_r <= Z_W'(16384);
        end else begin
          x_r <= -X_W'(dn_r);
          y_r <= X_W'(de_r);
          z_r <= -Z_W'(16384);
        end
      end else begin
        x_r <= X_W'(de_r);
        y_r <= X_W'(dn_r);
        z_r <= '0;
      end
    end
    if (cmd.iter) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end
    end
    if (cmd.pan) begin
      pan_r <= pnew;
      num_r <= num_c;
    end
    if (cmd.mul) begin
      span_r <= span_c;
      dv_r   <= span_c[SPAN_W-1] ? DIVR_W'(-span_c) : DIVR_W'(span_c);
      dvd_r  <= prod[DIV_W+14:15];
      rem_r  <= '0;
    end
    if (cmd.div) begin
      rem_r <= ge ? DIVR_W'(trial - {1'b0, dv_r}) : trial[DIVR_W-1:0];
      dvd_r <= {dvd_r[DIV_W-2:0], ge};
    end
    if (cmd.out_load) begin
      pan_out_r <= (pan_r > 32767) ? ANG_W'(32767) : pan_r[ANG_W-1:0];
      servo_r   <= servo_c;
    end
  end

  assign pan_angle     = pan_out_r;
  assign servo_command = servo_r;

endmodule

// ===== design/antenna_pan_pointing.sv =====
// Antenna pan pointing, top level: a controller and a datapath joined by commands.
// One item is processed at a time, passing in turn through the iterative CORDIC
// rotator and the 22-step restoring divider; no new item is taken until it is done.
// A new item is taken while the previous result waits in the output register.
// Reset (synchronous, active low) restores the register defaults and the side bit.
`timescale 1ns / 1ps
module antenna_pan_pointing #(
  parameter int CORDIC_STEPS = app_pkg::CORDIC_STEPS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [app_pkg::IN_W-1:0]        in_tdata,   // plane_north, plane_east, heading
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [app_pkg::OUT_W-1:0]       out_tdata,  // pan_angle, servo_command, zero pad
  input  logic                            cfg_we,
  input  logic [app_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [app_pkg::CFG_W-1:0]       cfg_wdata
);
  import app_pkg::*;

  cmd_t                      cmd;
  logic signed [ANG_W-1:0]   pan_angle;
  logic signed [SERVO_W-1:0] servo_command;

  app_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .cmd
  );

  app_dp u_dp (
    .clk, .rst_n, .cmd,
    .plane_north(in_tdata[23:0]),
    .plane_east(in_tdata[47:24]),
    .heading(in_tdata[63:48]),
    .cfg_we, .cfg_index, .cfg_wdata,
    .pan_angle, .servo_command
  );

  assign out_tdata = {1'b0, servo_command, pan_angle};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken while an item is in progress");

  a_servo_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(servo_command) <= 9600 && $signed(servo_command) >= -9600))
    else $error("servo command out of range");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule
